### hw/rtl/lbs_pkg.sv
package lbs_pkg;

    // Size limits of the effective registers
    localparam int MAX_CANVAS_WIDTH  = 256;
    localparam int MAX_CANVAS_HEIGHT = 256;
    localparam int MAX_WINDOW_WIDTH  = 2048;
    localparam int MAX_WINDOW_HEIGHT = 2048;

    // Field and datapath widths
    localparam int CSZ_W       = 9;               // canvas size, 1..256
    localparam int WSZ_W       = 12;              // window size, 1..2048
    localparam int COORD_W     = 11;              // window coordinate
    localparam int ADDR_W      = 16;              // canvas address
    localparam int CHAN_W      = 8;               // one color channel
    localparam int PIX_W       = 3 * CHAN_W;      // packed RGB
    localparam int PROD_W      = CSZ_W + WSZ_W;   // canvas size times window size
    localparam int DIV_NUM_W   = PROD_W;
    localparam int DIV_DEN_W   = WSZ_W;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes of an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CANVAS_WIDTH,
        CFG_CANVAS_HEIGHT,
        CFG_WINDOW_WIDTH,
        CFG_WINDOW_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] pixel_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] win_x;
        logic [COORD_W-1:0] win_y;
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
        logic               in_picture;
        logic               frame_end;
    } out_item_t;

    // One classified operation between front and back
    typedef struct packed {
        logic               is_scan;
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   color;
        logic [COORD_W-1:0] win_x;
        logic [COORD_W-1:0] win_y;
        logic               in_picture;
        logic               frame_end;
    } q_entry_t;

    // Geometry results and accumulator start values
    typedef struct packed {
        logic               busy;
        logic               load;
        logic [CSZ_W-1:0]   cw;
        logic [CSZ_W-1:0]   ch;
        logic [WSZ_W-1:0]   ww;
        logic [WSZ_W-1:0]   wh;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [WSZ_W-1:0]   dw;
        logic [WSZ_W-1:0]   dh;
        logic [CSZ_W-1:0]   qx;
        logic [CSZ_W-1:0]   rx;
        logic [CSZ_W-1:0]   qy;
        logic [CSZ_W-1:0]   ry;
        logic [CSZ_W-1:0]   init_sx;
        logic [WSZ_W-1:0]   init_rx;
        logic [CSZ_W-1:0]   init_sy;
        logic [WSZ_W-1:0]   init_ry;
    } geom_t;

    typedef enum logic [3:0] {
        G_IDLE,
        G_MUL,
        G_SIZE,
        G_OFFSET,
        G_STEP_X,
        G_STEP_Y,
        G_INIT_X,
        G_INIT_Y,
        G_LOAD
    } geom_state_t;

endpackage

### hw/rtl/lbs_divider.sv
module lbs_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           start,
    input  logic [lbs_pkg::DIV_NUM_W-1:0]  num,
    input  logic [lbs_pkg::DIV_DEN_W-1:0]  den,
    output logic                           done,
    output logic [lbs_pkg::DIV_NUM_W-1:0]  quo,
    output logic [lbs_pkg::DIV_DEN_W-1:0]  rem
);

    logic                           active_reg, active_next;
    logic                           done_reg, done_next;
    logic [lbs_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lbs_pkg::DIV_NUM_W-1:0]  quo_reg, quo_next;
    logic [lbs_pkg::DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [lbs_pkg::DIV_DEN_W-1:0]  den_reg, den_next;
    logic [lbs_pkg::DIV_DEN_W:0]    shifted;
    logic [lbs_pkg::DIV_DEN_W:0]    trial;
    logic                           ge;

    // One restoring step: bring down a numerator bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[lbs_pkg::DIV_NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        if (clear)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            rem_next = ge ? trial[lbs_pkg::DIV_DEN_W-1:0] : shifted[lbs_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[lbs_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + lbs_pkg::DIV_CNT_W'(1);
            if (cnt_reg == lbs_pkg::DIV_CNT_W'(lbs_pkg::DIV_NUM_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
        else if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            quo_next    = num;
            rem_next    = '0;
            den_next    = den;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/lbs_geometry.sv
module lbs_geometry (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [lbs_pkg::COORD_W-1:0]      col,
    input  logic [lbs_pkg::COORD_W-1:0]      row,
    output lbs_pkg::geom_t                   geom
);

    localparam int EXT_W = lbs_pkg::COORD_W + 2;

    lbs_pkg::geom_state_t state_reg, state_next;
    logic                 issued_reg, issued_next;

    logic [lbs_pkg::CSZ_W-1:0]   cw_cfg_reg, ch_cfg_reg;
    logic [lbs_pkg::WSZ_W-1:0]   ww_cfg_reg, wh_cfg_reg;
    logic [lbs_pkg::CSZ_W-1:0]   cw_c, ch_c;
    logic [lbs_pkg::WSZ_W-1:0]   ww_c, wh_c;

    logic [lbs_pkg::PROD_W-1:0]  prod_h_reg, prod_v_reg;
    logic                        fit_h;
    logic [lbs_pkg::WSZ_W-1:0]   dw_reg, dh_reg;
    logic [lbs_pkg::COORD_W-1:0] x0_reg, y0_reg;
    logic [lbs_pkg::CSZ_W-1:0]   qx_reg, rx_reg, qy_reg, ry_reg;
    logic [lbs_pkg::CSZ_W-1:0]   init_sx_reg, init_sy_reg;
    logic [lbs_pkg::WSZ_W-1:0]   init_rx_reg, init_ry_reg;
    logic [lbs_pkg::WSZ_W-1:0]   spare_w, spare_h;

    logic                           div_state;
    logic                           div_start;
    logic                           div_done;
    logic [lbs_pkg::DIV_NUM_W-1:0]  div_num, div_quo;
    logic [lbs_pkg::DIV_DEN_W-1:0]  div_den, div_rem;
    logic [EXT_W-1:0]               x_end, y_end;
    logic                           in_x, in_y;
    logic [lbs_pkg::PROD_W-1:0]     off_x_prod, off_y_prod;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_cfg_reg <= lbs_pkg::CSZ_W'(256);
            ch_cfg_reg <= lbs_pkg::CSZ_W'(256);
            ww_cfg_reg <= lbs_pkg::WSZ_W'(256);
            wh_cfg_reg <= lbs_pkg::WSZ_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbs_pkg::CFG_CANVAS_WIDTH:  cw_cfg_reg <= cfg_data[lbs_pkg::CSZ_W-1:0];
                lbs_pkg::CFG_CANVAS_HEIGHT: ch_cfg_reg <= cfg_data[lbs_pkg::CSZ_W-1:0];
                lbs_pkg::CFG_WINDOW_WIDTH:  ww_cfg_reg <= cfg_data[lbs_pkg::WSZ_W-1:0];
                lbs_pkg::CFG_WINDOW_HEIGHT: wh_cfg_reg <= cfg_data[lbs_pkg::WSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate sizes, zero counts as one
    always_comb
    begin
        cw_c = (cw_cfg_reg == '0) ? lbs_pkg::CSZ_W'(1) :
               (cw_cfg_reg > lbs_pkg::CSZ_W'(lbs_pkg::MAX_CANVAS_WIDTH)) ?
               lbs_pkg::CSZ_W'(lbs_pkg::MAX_CANVAS_WIDTH) : cw_cfg_reg;
        ch_c = (ch_cfg_reg == '0) ? lbs_pkg::CSZ_W'(1) :
               (ch_cfg_reg > lbs_pkg::CSZ_W'(lbs_pkg::MAX_CANVAS_HEIGHT)) ?
               lbs_pkg::CSZ_W'(lbs_pkg::MAX_CANVAS_HEIGHT) : ch_cfg_reg;
        ww_c = (ww_cfg_reg == '0) ? lbs_pkg::WSZ_W'(1) :
               (ww_cfg_reg > lbs_pkg::WSZ_W'(lbs_pkg::MAX_WINDOW_WIDTH)) ?
               lbs_pkg::WSZ_W'(lbs_pkg::MAX_WINDOW_WIDTH) : ww_cfg_reg;
        wh_c = (wh_cfg_reg == '0) ? lbs_pkg::WSZ_W'(1) :
               (wh_cfg_reg > lbs_pkg::WSZ_W'(lbs_pkg::MAX_WINDOW_HEIGHT)) ?
               lbs_pkg::WSZ_W'(lbs_pkg::MAX_WINDOW_HEIGHT) : wh_cfg_reg;
    end

    // Picture fills the height when the canvas is relatively taller
    assign fit_h   = prod_h_reg <= prod_v_reg;
    assign spare_w = ww_c - dw_reg;
    assign spare_h = wh_c - dh_reg;

    // Current scan position against the new drawn area
    assign x_end = EXT_W'(x0_reg) + EXT_W'(dw_reg);
    assign y_end = EXT_W'(y0_reg) + EXT_W'(dh_reg);
    assign in_x  = (col >= x0_reg) && (EXT_W'(col) < x_end);
    assign in_y  = (row >= y0_reg) && (EXT_W'(row) < y_end);
    assign off_x_prod = in_x ? lbs_pkg::PROD_W'(col - x0_reg) * lbs_pkg::PROD_W'(cw_c) : '0;
    assign off_y_prod = in_y ? lbs_pkg::PROD_W'(row - y0_reg) * lbs_pkg::PROD_W'(ch_c) : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbs_pkg::G_IDLE:   state_next = lbs_pkg::G_IDLE;
            lbs_pkg::G_MUL:    state_next = lbs_pkg::G_SIZE;
            lbs_pkg::G_SIZE:   state_next = div_done ? lbs_pkg::G_OFFSET : lbs_pkg::G_SIZE;
            lbs_pkg::G_OFFSET: state_next = lbs_pkg::G_STEP_X;
            lbs_pkg::G_STEP_X: state_next = div_done ? lbs_pkg::G_STEP_Y : lbs_pkg::G_STEP_X;
            lbs_pkg::G_STEP_Y: state_next = div_done ? lbs_pkg::G_INIT_X : lbs_pkg::G_STEP_Y;
            lbs_pkg::G_INIT_X: state_next = div_done ? lbs_pkg::G_INIT_Y : lbs_pkg::G_INIT_X;
            lbs_pkg::G_INIT_Y: state_next = div_done ? lbs_pkg::G_LOAD : lbs_pkg::G_INIT_Y;
            lbs_pkg::G_LOAD:   state_next = lbs_pkg::G_IDLE;
            default:           state_next = lbs_pkg::G_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = lbs_pkg::G_MUL;
        end
    end

    // Divider operands per state
    always_comb
    begin
        div_state = state_reg inside {lbs_pkg::G_SIZE, lbs_pkg::G_STEP_X, lbs_pkg::G_STEP_Y,
                                      lbs_pkg::G_INIT_X, lbs_pkg::G_INIT_Y};
        div_start = div_state && !issued_reg && !cfg_we;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            lbs_pkg::G_SIZE:
            begin
                div_num = fit_h ? prod_h_reg : prod_v_reg;
                div_den = fit_h ? lbs_pkg::DIV_DEN_W'(ch_c) : lbs_pkg::DIV_DEN_W'(cw_c);
            end
            lbs_pkg::G_STEP_X:
            begin
                div_num = lbs_pkg::DIV_NUM_W'(cw_c);
                div_den = dw_reg;
            end
            lbs_pkg::G_STEP_Y:
            begin
                div_num = lbs_pkg::DIV_NUM_W'(ch_c);
                div_den = dh_reg;
            end
            lbs_pkg::G_INIT_X:
            begin
                div_num = off_x_prod;
                div_den = dw_reg;
            end
            lbs_pkg::G_INIT_Y:
            begin
                div_num = off_y_prod;
                div_den = dh_reg;
            end
            default: ;
        endcase
        issued_next = issued_reg;
        if (cfg_we || div_done)
        begin
            issued_next = 1'b0;
        end
        else if (div_start)
        begin
            issued_next = 1'b1;
        end
    end

    // Restart the whole computation after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lbs_pkg::G_MUL;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    // Capture geometry results
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lbs_pkg::G_MUL:
            begin
                prod_h_reg <= lbs_pkg::PROD_W'(cw_c) * lbs_pkg::PROD_W'(wh_c);
                prod_v_reg <= lbs_pkg::PROD_W'(ch_c) * lbs_pkg::PROD_W'(ww_c);
            end
            lbs_pkg::G_SIZE:
            begin
                if (div_done)
                begin
                    if (fit_h)
                    begin
                        dh_reg <= wh_c;
                        dw_reg <= div_quo[lbs_pkg::WSZ_W-1:0];
                    end
                    else
                    begin
                        dw_reg <= ww_c;
                        dh_reg <= div_quo[lbs_pkg::WSZ_W-1:0];
                    end
                end
            end
            lbs_pkg::G_OFFSET:
            begin
                x0_reg <= fit_h ? spare_w[lbs_pkg::WSZ_W-1:1] : '0;
                y0_reg <= fit_h ? '0 : spare_h[lbs_pkg::WSZ_W-1:1];
            end
            lbs_pkg::G_STEP_X:
            begin
                if (div_done)
                begin
                    qx_reg <= div_quo[lbs_pkg::CSZ_W-1:0];
                    rx_reg <= div_rem[lbs_pkg::CSZ_W-1:0];
                end
            end
            lbs_pkg::G_STEP_Y:
            begin
                if (div_done)
                begin
                    qy_reg <= div_quo[lbs_pkg::CSZ_W-1:0];
                    ry_reg <= div_rem[lbs_pkg::CSZ_W-1:0];
                end
            end
            lbs_pkg::G_INIT_X:
            begin
                if (div_done)
                begin
                    init_sx_reg <= div_quo[lbs_pkg::CSZ_W-1:0];
                    init_rx_reg <= div_rem;
                end
            end
            lbs_pkg::G_INIT_Y:
            begin
                if (div_done)
                begin
                    init_sy_reg <= div_quo[lbs_pkg::CSZ_W-1:0];
                    init_ry_reg <= div_rem;
                end
            end
            default: ;
        endcase
    end

    lbs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cfg_we),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_comb
    begin
        geom.busy    = state_reg != lbs_pkg::G_IDLE;
        geom.load    = state_reg == lbs_pkg::G_LOAD;
        geom.cw      = cw_c;
        geom.ch      = ch_c;
        geom.ww      = ww_c;
        geom.wh      = wh_c;
        geom.x0      = x0_reg;
        geom.y0      = y0_reg;
        geom.dw      = dw_reg;
        geom.dh      = dh_reg;
        geom.qx      = qx_reg;
        geom.rx      = rx_reg;
        geom.qy      = qy_reg;
        geom.ry      = ry_reg;
        geom.init_sx = init_sx_reg;
        geom.init_rx = init_rx_reg;
        geom.init_sy = init_sy_reg;
        geom.init_ry = init_ry_reg;
    end

endmodule

### hw/rtl/lbs_front.sv
module lbs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  lbs_pkg::in_item_t            item,
    output logic                         item_ready,
    input  lbs_pkg::geom_t               geom,
    input  logic                         queue_full,
    output logic                         push,
    output lbs_pkg::q_entry_t            entry,
    output logic [lbs_pkg::COORD_W-1:0]  col,
    output logic [lbs_pkg::COORD_W-1:0]  row
);

    localparam int EXT_W = lbs_pkg::COORD_W + 2;
    localparam int ACC_W = lbs_pkg::WSZ_W + 1;

    logic [lbs_pkg::COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [lbs_pkg::CSZ_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [lbs_pkg::WSZ_W-1:0]   rxa_reg, rxa_next, rya_reg, rya_next;

    logic             is_scan;
    logic [EXT_W-1:0] x_end, y_end;
    logic             in_x, in_y;
    logic             last_col, last_row;
    logic [ACC_W-1:0] acc_x, acc_y, red_x, red_y;
    logic             carry_x, carry_y;

    assign item_ready = !queue_full && !geom.busy;
    assign push       = item_valid && item_ready;
    assign is_scan    = item.op == lbs_pkg::OP_SCAN;

    // Classify the current scan position
    assign x_end    = EXT_W'(geom.x0) + EXT_W'(geom.dw);
    assign y_end    = EXT_W'(geom.y0) + EXT_W'(geom.dh);
    assign in_x     = (col_reg >= geom.x0) && (EXT_W'(col_reg) < x_end);
    assign in_y     = (row_reg >= geom.y0) && (EXT_W'(row_reg) < y_end);
    assign last_col = (lbs_pkg::WSZ_W'(col_reg) + lbs_pkg::WSZ_W'(1)) >= geom.ww;
    assign last_row = (lbs_pkg::WSZ_W'(row_reg) + lbs_pkg::WSZ_W'(1)) >= geom.wh;

    // Step the source accumulators by quotient and remainder
    assign acc_x   = ACC_W'(rxa_reg) + ACC_W'(geom.rx);
    assign acc_y   = ACC_W'(rya_reg) + ACC_W'(geom.ry);
    assign carry_x = acc_x >= ACC_W'(geom.dw);
    assign carry_y = acc_y >= ACC_W'(geom.dh);
    assign red_x   = carry_x ? acc_x - ACC_W'(geom.dw) : acc_x;
    assign red_y   = carry_y ? acc_y - ACC_W'(geom.dh) : acc_y;

    // Build the queue entry
    always_comb
    begin
        entry.is_scan    = is_scan;
        entry.addr       = is_scan ?
                           lbs_pkg::ADDR_W'(sx_reg) +
                           lbs_pkg::ADDR_W'(sy_reg) * lbs_pkg::ADDR_W'(geom.cw) :
                           item.pixel_index;
        entry.color      = {item.red, item.green, item.blue};
        entry.win_x      = col_reg;
        entry.win_y      = row_reg;
        entry.in_picture = in_x && in_y;
        entry.frame_end  = last_col && last_row;
    end

    // Advance the scan position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        rxa_next = rxa_reg;
        rya_next = rya_reg;
        if (geom.load)
        begin
            sx_next  = geom.init_sx;
            rxa_next = geom.init_rx;
            sy_next  = geom.init_sy;
            rya_next = geom.init_ry;
        end
        else if (push && is_scan)
        begin
            if (last_col)
            begin
                col_next = '0;
                sx_next  = '0;
                rxa_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    sy_next  = '0;
                    rya_next = '0;
                end
                else
                begin
                    row_next = row_reg + lbs_pkg::COORD_W'(1);
                    if (in_y)
                    begin
                        sy_next  = sy_reg + geom.qy + lbs_pkg::CSZ_W'(carry_y);
                        rya_next = red_y[lbs_pkg::WSZ_W-1:0];
                    end
                end
            end
            else
            begin
                col_next = col_reg + lbs_pkg::COORD_W'(1);
                if (in_x)
                begin
                    sx_next  = sx_reg + geom.qx + lbs_pkg::CSZ_W'(carry_x);
                    rxa_next = red_x[lbs_pkg::WSZ_W-1:0];
                end
            end
        end
    end

    // Hold scan position and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            rxa_reg <= '0;
            rya_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            rxa_reg <= rxa_next;
            rya_reg <= rya_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

`ifndef ASSERT_OFF
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        push && entry.is_scan && entry.frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("scan did not return to origin after frame end");

    a_source_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        push && entry.is_scan && entry.in_picture |-> sx_reg < geom.cw && sy_reg < geom.ch)
        else $error("source coordinate outside canvas");

    a_rem_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !geom.busy && geom.dw != '0 |-> rxa_reg < geom.dw)
        else $error("column accumulator remainder out of range");

    a_rem_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !geom.busy && geom.dh != '0 |-> rya_reg < geom.dh)
        else $error("row accumulator remainder out of range");
`endif

endmodule

### hw/rtl/lbs_queue.sv
module lbs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lbs_pkg::q_entry_t  push_data,
    input  logic               pop,
    output lbs_pkg::q_entry_t  head,
    output logic               head_valid,
    output logic               full
);

    lbs_pkg::q_entry_t            slots [lbs_pkg::QUEUE_DEPTH];
    logic [lbs_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lbs_pkg::QPTR_W:0]     count_reg, count_next;

    assign head       = slots[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == (lbs_pkg::QPTR_W + 1)'(lbs_pkg::QUEUE_DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (lbs_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (lbs_pkg::QPTR_W + 1)'(1);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lbs_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lbs_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/lbs_back.sv
module lbs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lbs_pkg::q_entry_t   head,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output lbs_pkg::out_item_t  result
);

    logic [lbs_pkg::PIX_W-1:0]   canvas_mem [2**lbs_pkg::ADDR_W];
    logic [lbs_pkg::PIX_W-1:0]   rd_reg;
    logic [lbs_pkg::COORD_W-1:0] win_x_reg, win_y_reg;
    logic                        in_pic_reg, frame_end_reg;
    logic                        out_valid_reg;
    logic                        pop_scan;

    // Take a write at once, a scan when the output slot frees up
    assign pop      = head_valid && (!head.is_scan || !out_valid_reg || result_ready);
    assign pop_scan = pop && head.is_scan;

    // Canvas memory: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (pop && !head.is_scan)
        begin
            canvas_mem[head.addr] <= head.color;
        end
        if (pop_scan)
        begin
            rd_reg <= canvas_mem[head.addr];
        end
    end

    // Hold result fields while stalled
    always_ff @(posedge clk)
    begin
        if (pop_scan)
        begin
            win_x_reg     <= head.win_x;
            win_y_reg     <= head.win_y;
            in_pic_reg    <= head.in_picture;
            frame_end_reg <= head.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_scan)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Blank bar pixels
    always_comb
    begin
        result.win_x      = win_x_reg;
        result.win_y      = win_y_reg;
        result.out_red    = in_pic_reg ? rd_reg[2*lbs_pkg::CHAN_W +: lbs_pkg::CHAN_W] : '0;
        result.out_green  = in_pic_reg ? rd_reg[lbs_pkg::CHAN_W +: lbs_pkg::CHAN_W] : '0;
        result.out_blue   = in_pic_reg ? rd_reg[0 +: lbs_pkg::CHAN_W] : '0;
        result.in_picture = in_pic_reg;
        result.frame_end  = frame_end_reg;
    end

    assign result_valid = out_valid_reg;

endmodule

### hw/rtl/letterbox_nearest_scaler.sv
// Letterbox nearest-neighbor scaler.
// Input channel (item_valid/item_ready/item): op OP_WRITE stores red, green,
// blue at canvas address pixel_index; op OP_SCAN asks for the next window
// pixel in row-major order. Output channel (result_valid/result_ready/result)
// carries one transaction per scan: position, color (black in the bars),
// in_picture and frame_end on the last pixel of the window.
// Configuration: cfg_we writes cfg_data into register cfg_index (canvas width,
// canvas height, window width, window height) on the same edge.
// Throughput: one item per cycle while item_ready is high, set by the
// single-port canvas memory, which takes one write or one read each cycle;
// writes and scans stay in order; a scan result is read into a register.
// A four-entry queue parts front and back, so items keep being accepted while
// the receiver stalls until the queue fills; then item_ready drops.
// After reset and after every configuration write, the geometry unit runs
// five serial 21-bit divisions with item_ready low.
// Reset returns the scan to the origin and the registers to 256; the canvas
// memory is not cleared and must be written before it is scanned.
module letterbox_nearest_scaler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  lbs_pkg::in_item_t                item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output lbs_pkg::out_item_t               result,
    input  logic                             cfg_we,
    input  logic [lbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lbs_pkg::geom_t              geom;
    lbs_pkg::q_entry_t           entry;
    lbs_pkg::q_entry_t           head;
    logic                        push, pop, head_valid, queue_full;
    logic [lbs_pkg::COORD_W-1:0] col, row;

    lbs_geometry u_geometry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col       (col),
        .row       (row),
        .geom      (geom)
    );

    lbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .geom       (geom),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry),
        .col        (col),
        .row        (row)
    );

    lbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    lbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
